@@ rtl/kwhpm_pkg.sv @@
`default_nettype none

package kwhpm_pkg;

  typedef struct packed {
    logic signed [23:0] sample;
    logic [2:0]         channel;
    logic               last_in_frame;
  } in_item_t;

  typedef struct packed {
    logic [47:0] hop_power;
    logic        saturated;
  } out_item_t;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StMul,
    StFrame,
    StDiv,
    StResult
  } state_e;

  localparam int NumCoefs = 7;

  localparam logic [2:0] RegShelfB0    = 3'd0;
  localparam logic [2:0] RegShelfB1    = 3'd1;
  localparam logic [2:0] RegShelfB2    = 3'd2;
  localparam logic [2:0] RegShelfA1    = 3'd3;
  localparam logic [2:0] RegShelfA2    = 3'd4;
  localparam logic [2:0] RegHighpassA1 = 3'd5;
  localparam logic [2:0] RegHighpassA2 = 3'd6;
  localparam logic [2:0] RegHopLength  = 3'd7;

  localparam logic [2:0] OpB0X   = 3'd0;
  localparam logic [2:0] OpB1X   = 3'd1;
  localparam logic [2:0] OpA1Y1  = 3'd2;
  localparam logic [2:0] OpB2X   = 3'd3;
  localparam logic [2:0] OpA2Y1  = 3'd4;
  localparam logic [2:0] OpHpA1  = 3'd5;
  localparam logic [2:0] OpHpA2  = 3'd6;
  localparam logic [2:0] OpSquare = 3'd7;

  localparam logic signed [31:0] CoefReset [NumCoefs] = '{
    32'sd412081942, -32'sd722546695, 32'sd321691119, -32'sd453832898,
    32'sd196623810, -32'sd534199295, 32'sd265770496
  };

  localparam logic [15:0] HopLengthReset = 16'd4800;

  localparam logic signed [57:0] SatHi = 58'sd549755813887;
  localparam logic signed [57:0] SatLo = -58'sd549755813888;

  function automatic logic signed [39:0] sat40(input logic signed [57:0] v);
    logic signed [39:0] r;
    if (v > SatHi) begin
      r = 40'(SatHi);
    end else if (v < SatLo) begin
      r = 40'(SatLo);
    end else begin
      r = 40'(v);
    end
    return r;
  endfunction

  function automatic logic ovf40(input logic signed [57:0] v);
    return (v > SatHi) || (v < SatLo);
  endfunction

endpackage

`default_nettype wire

@@ rtl/k_weighted_hop_power_meter_core.sv @@
// K-weighted hop power meter. Each input transaction carries one audio sample with its channel
// and an end-of-frame mark; the sample runs through its channel's shelf and high-pass stages,
// its square is added to the hop sum, and after hop_length frames one transaction with the mean
// square is offered. The block takes one sample at a time: a sample of a valid channel first
// reads its filter memory, then forms eight products on one shared multiplier, each from a high
// and a low partial product and a combining step; a sample of an unused channel skips the
// filter, and a sample that closes a hop adds a bit-serial divide by the hop length and the
// result hand-off, and stays busy longer while an earlier result still waits on a stalled
// output. Filter memory reads as zero after reset through one valid bit per channel.
`default_nettype none

module k_weighted_hop_power_meter_core import kwhpm_pkg::*; #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_item_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int Depth = 4 * MAX_CHANNELS;
  localparam int AW = $clog2(Depth);
  localparam int ChW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  state_e state_q, state_d;
  logic signed [31:0] coef_q [NumCoefs];
  logic [15:0] hop_len_q;
  logic [2:0]  k_q, k_d;
  logic [2:0]  op_q, op_d;
  logic [1:0]  phase_q, phase_d;
  logic [63:0] power_sum_q, power_sum_d;
  logic [15:0] frames_q, frames_d;
  logic        sat_seen_q, sat_seen_d;
  logic [5:0]  div_cnt_q, div_cnt_d;
  logic        out_valid_q, out_valid_d;
  logic [MAX_CHANNELS-1:0] row_valid_q;

  logic signed [39:0] x_q;
  logic [2:0]  ch_q;
  logic        last_q;
  logic signed [39:0] s_q [4];
  logic signed [61:0] hi_q, lo_q;
  logic signed [39:0] y1_q, y2_q;
  logic signed [57:0] t_q;
  logic [63:0] div_quo_q;
  logic [15:0] div_rem_q, div_den_q;
  logic        div_sat_q;
  out_item_t   out_q;

  logic [39:0] mem [Depth];
  logic [39:0] rd_data_q;

  logic        accept;
  logic        in_range;
  logic        rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [1:0]  wr_idx;
  logic signed [39:0] wr_data;
  logic [39:0] mag;
  logic signed [31:0] coef_sel;
  logic signed [39:0] v_sel;
  logic [39:0] vb;
  logic signed [40:0] mul_a;
  logic signed [20:0] mul_b;
  logic signed [61:0] prod;
  logic signed [81:0] full, rnd_full;
  logic signed [57:0] rnd, e, y2e;
  logic [63:0] sq;
  logic [64:0] sum_ext;
  logic [15:0] frames_inc, hop_eff;
  logic [16:0] trial;
  logic        ge;
  logic        load_out;
  logic [63:0] q;

  assign in_stall_o  = (state_q != StIdle);
  assign accept      = in_valid_i && (state_q == StIdle);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign in_range    = {29'b0, in_data_i.channel} < 32'(MAX_CHANNELS);

  always_comb begin
    mag = y2_q[39] ? 40'(-y2_q) : 40'(y2_q);
    case (op_q)
      OpB0X:   coef_sel = coef_q[RegShelfB0];
      OpB1X:   coef_sel = coef_q[RegShelfB1];
      OpA1Y1:  coef_sel = coef_q[RegShelfA1];
      OpB2X:   coef_sel = coef_q[RegShelfB2];
      OpA2Y1:  coef_sel = coef_q[RegShelfA2];
      OpHpA1:  coef_sel = coef_q[RegHighpassA1];
      OpHpA2:  coef_sel = coef_q[RegHighpassA2];
      default: coef_sel = '0;
    endcase
    case (op_q)
      OpA1Y1, OpA2Y1: v_sel = y1_q;
      OpHpA1, OpHpA2: v_sel = y2_q;
      default:        v_sel = x_q;
    endcase
    vb = (op_q == OpSquare) ? mag : 40'(v_sel);
    mul_a = (op_q == OpSquare) ? $signed({1'b0, mag}) : 41'(coef_sel);
    if (phase_q == 2'd0) begin
      mul_b = (op_q == OpSquare) ? $signed({1'b0, vb[39:20]}) : $signed({vb[39], vb[39:20]});
    end else begin
      mul_b = $signed({1'b0, vb[19:0]});
    end
    prod = mul_a * mul_b;

    full     = (82'(hi_q) <<< 20) + 82'(lo_q);
    rnd_full = full + 82'sd134217728 - $signed(82'(full[81]));
    rnd      = 58'(rnd_full >>> 28);
    sq       = 64'(full[81:24]);
    sum_ext  = {1'b0, power_sum_q} + {1'b0, sq};

    case (op_q)
      OpB0X:   e = rnd + 58'(s_q[0]);
      OpA1Y1:  e = t_q - rnd + 58'(s_q[1]);
      OpA2Y1:  e = t_q - rnd;
      OpHpA1:  e = -(58'(y1_q) <<< 1) - rnd + 58'(s_q[3]);
      OpHpA2:  e = 58'(y1_q) - rnd;
      default: e = '0;
    endcase
    y2e = 58'(y1_q) + 58'(s_q[2]);

    case (op_q)
      OpA1Y1:  wr_idx = 2'd0;
      OpA2Y1:  wr_idx = 2'd1;
      OpHpA1:  wr_idx = 2'd2;
      default: wr_idx = 2'd3;
    endcase
    wr_en   = (state_q == StMul) && (phase_q == 2'd2) &&
              ((op_q == OpA1Y1) || (op_q == OpA2Y1) || (op_q == OpHpA1) || (op_q == OpHpA2));
    wr_addr = AW'({ch_q, wr_idx});
    wr_data = sat40(e);
    rd_en   = (state_q == StRead) && (k_q < 3'd4);
    rd_addr = AW'({ch_q, k_q[1:0]});

    frames_inc = frames_q + 16'd1;
    hop_eff    = (hop_len_q == 16'd0) ? 16'd1 : hop_len_q;
    trial      = {div_rem_q, div_quo_q[63]};
    ge         = trial >= {1'b0, div_den_q};
    q          = div_quo_q;
    load_out   = (state_q == StResult) && (!out_valid_q || !out_stall_i);
  end

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    op_d        = op_q;
    phase_d     = phase_q;
    power_sum_d = power_sum_q;
    frames_d    = frames_q;
    sat_seen_d  = sat_seen_q;
    div_cnt_d   = div_cnt_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (accept) begin
          k_d     = '0;
          state_d = in_range ? StRead : StFrame;
        end
      end
      StRead: begin
        k_d = k_q + 3'd1;
        if (k_q == 3'd4) begin
          op_d    = OpB0X;
          phase_d = 2'd0;
          state_d = StMul;
        end
      end
      StMul: begin
        phase_d = phase_q + 2'd1;
        if (phase_q == 2'd2) begin
          phase_d = 2'd0;
          op_d    = op_q + 3'd1;
          if ((op_q == OpB0X) || wr_en) begin
            sat_seen_d = sat_seen_q | ovf40(e);
          end
          if (op_q == OpA2Y1) begin
            sat_seen_d = sat_seen_q | ovf40(e) | ovf40(y2e);
          end
          if (op_q == OpSquare) begin
            if (sum_ext[64]) begin
              power_sum_d = '1;
              sat_seen_d  = 1'b1;
            end else begin
              power_sum_d = sum_ext[63:0];
            end
            state_d = StFrame;
          end
        end
      end
      StFrame: begin
        state_d = StIdle;
        if (last_q) begin
          frames_d = frames_inc;
          if (frames_inc >= hop_eff) begin
            frames_d    = '0;
            power_sum_d = '0;
            sat_seen_d  = 1'b0;
            div_cnt_d   = 6'd63;
            state_d     = StDiv;
          end
        end
      end
      StDiv: begin
        div_cnt_d = div_cnt_q - 6'd1;
        if (div_cnt_q == 6'd0) begin
          state_d = StResult;
        end
      end
      StResult: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      k_q         <= '0;
      op_q        <= '0;
      phase_q     <= '0;
      power_sum_q <= '0;
      frames_q    <= '0;
      sat_seen_q  <= 1'b0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      row_valid_q <= '0;
      hop_len_q   <= HopLengthReset;
      for (int i = 0; i < NumCoefs; i++) begin
        coef_q[i] <= CoefReset[i];
      end
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      op_q        <= op_d;
      phase_q     <= phase_d;
      power_sum_q <= power_sum_d;
      frames_q    <= frames_d;
      sat_seen_q  <= sat_seen_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
      if (wr_en) begin
        row_valid_q[ch_q[ChW-1:0]] <= 1'b1;
      end
      if (cfg_valid_i) begin
        if (cfg_index_i == RegHopLength) begin
          hop_len_q <= cfg_data_i[15:0];
        end else begin
          coef_q[cfg_index_i] <= $signed(cfg_data_i);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q    <= 40'(in_data_i.sample) <<< 9;
      ch_q   <= in_data_i.channel;
      last_q <= in_data_i.last_in_frame;
    end
    if ((state_q == StRead) && (k_q != 3'd0)) begin
      s_q[k_q[1:0] - 2'd1] <= row_valid_q[ch_q[ChW-1:0]] ? $signed(rd_data_q) : '0;
    end
    if (state_q == StMul) begin
      if (phase_q == 2'd0) begin
        hi_q <= prod;
      end
      if (phase_q == 2'd1) begin
        lo_q <= prod;
      end
      if (phase_q == 2'd2) begin
        if (op_q == OpB0X) begin
          y1_q <= sat40(e);
        end
        if ((op_q == OpB1X) || (op_q == OpB2X)) begin
          t_q <= rnd;
        end
        if (op_q == OpA2Y1) begin
          y2_q <= sat40(y2e);
        end
      end
    end
    if ((state_q == StFrame) && last_q && (frames_inc >= hop_eff)) begin
      div_quo_q <= power_sum_q;
      div_rem_q <= '0;
      div_den_q <= hop_eff;
      div_sat_q <= sat_seen_q;
    end
    if (state_q == StDiv) begin
      div_rem_q <= ge ? 16'(trial - {1'b0, div_den_q}) : trial[15:0];
      div_quo_q <= {div_quo_q[62:0], ge};
    end
    if (load_out) begin
      out_q.hop_power <= (|q[63:48]) ? '1 : q[47:0];
      out_q.saturated <= div_sat_q | (|q[63:48]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/kwhpm_checker.sv @@
`default_nettype none

module kwhpm_checker import kwhpm_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input out_item_t  out_data_o
);

  // An accepted sample keeps the block busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken twice in a row");

  // A new result only appears while the block was busy working on a hop.
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared while idle");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result transaction changed");

endmodule

bind k_weighted_hop_power_meter_core kwhpm_checker u_kwhpm_checker (.*);

`default_nettype wire
